[hdl/pgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types and codes for the two-level page table manager.
// ----------------------------------------------------------------------------
package pgt_pkg;

  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int FRAME_W     = 20;
  localparam int CNT_W       = 13;
  localparam int DIR_ENTRIES = 1024;
  localparam int FLAG_USER   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_ALREADY    = 3'd2;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd3;
  localparam logic [2:0] ST_NO_TABLES  = 3'd4;

  typedef struct packed {
    logic             present;
    logic             writable;
    logic             user;
    logic [IDX_W-1:0] table_num;
  } dir_entry_t;

  // One classified request as it waits between the front and back parts.
  typedef struct packed {
    logic [1:0]         op;
    logic               misaligned;
    logic [IDX_W-1:0]   dir;
    logic [IDX_W-1:0]   tab;
    logic [OFF_W-1:0]   off;
    logic [FRAME_W-1:0] frame;
    logic [OFF_W-1:0]   flags;
  } pgt_item_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_ctl_t;

endpackage

[hdl/pgt_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface pgt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] page_flags;

  modport source (output valid, op, virt_addr, phys_addr, page_flags, input ready);
  modport sink   (input valid, op, virt_addr, phys_addr, page_flags, output ready);
endinterface

[hdl/pgt_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface pgt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] phys_out;
  logic [12:0] mapped_count;

  modport source (output valid, status, phys_out, mapped_count, input ready);
  modport sink   (input valid, status, phys_out, mapped_count, output ready);
endinterface

[hdl/pgt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_front
// Accepts requests, splits the address and checks alignment, and holds
// the classified requests in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module pgt_front
  import pgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pgt_req_if.sink     req,
  input  back_ctl_t   ctl,
  output logic        item_valid,
  output pgt_item_t   item
);

  pgt_item_t  queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  pgt_item_t  cls;

  assign req.ready = (fill != 2'd2) && !ctl.busy;
  assign push      = req.valid && req.ready;

  always_comb begin
    cls.op    = req.op;
    cls.dir   = req.virt_addr[31:22];
    cls.tab   = req.virt_addr[21:12];
    cls.off   = req.virt_addr[11:0];
    cls.frame = req.phys_addr[31:12];
    cls.flags = req.page_flags;
    case (req.op)
      OP_MAP:   cls.misaligned = (req.virt_addr[11:0] != '0) || (req.phys_addr[11:0] != '0);
      OP_UNMAP: cls.misaligned = (req.virt_addr[11:0] != '0);
      default:  cls.misaligned = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (ctl.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, ctl.pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign item_valid = (fill != 2'd0);
  assign item       = queue[rd_ptr];

endmodule

[hdl/pgt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_back
// Walks the directory and table memories for one request at a time,
// updates the tables and the page count, and registers the result.
// After reset both memories are cleared, one table entry per cycle.
// ----------------------------------------------------------------------------
module pgt_back
  import pgt_pkg::*;
#(
  parameter int NUM_TABLE_PAGES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  pgt_item_t item,
  output back_ctl_t ctl,
  pgt_rsp_if.source rsp
);

  localparam int TW = (NUM_TABLE_PAGES > 1) ? $clog2(NUM_TABLE_PAGES) : 1;
  localparam int NW = $clog2(NUM_TABLE_PAGES + 1);
  localparam int AW = TW + IDX_W;
  localparam int TABLE_DEPTH = NUM_TABLE_PAGES * DIR_ENTRIES;
  localparam logic [NW-1:0] POOL_SIZE = NW'(NUM_TABLE_PAGES);

  localparam logic [1:0] BS_CLEAR = 2'd0;
  localparam logic [1:0] BS_IDLE  = 2'd1;
  localparam logic [1:0] BS_DIR   = 2'd2;
  localparam logic [1:0] BS_TAB   = 2'd3;

  dir_entry_t  dir_mem [DIR_ENTRIES];
  logic [31:0] tab_mem [TABLE_DEPTH];

  logic [1:0]       state, state_next;
  logic [AW-1:0]    clr_idx;
  pgt_item_t        cur;
  logic [TW-1:0]    tnum, tnum_next;
  logic [NW-1:0]    next_free, next_free_next;
  logic [CNT_W-1:0] count, count_next;
  dir_entry_t       dir_q;
  logic [31:0]      tab_q;

  logic             dir_re, dir_we, tab_re, tab_we;
  logic [IDX_W-1:0] dir_raddr, dir_waddr;
  dir_entry_t       dir_wdata;
  logic [AW-1:0]    tab_addr;
  logic [31:0]      tab_wdata;
  logic             load_out, can_out;
  logic [2:0]       res_status;
  logic [31:0]      res_phys;

  logic        ov;
  logic [2:0]  ostatus;
  logic [31:0] ophys;

  assign can_out = !ov || rsp.ready;

  always_comb begin
    state_next     = state;
    dir_re         = 1'b0;
    dir_raddr      = item.dir;
    dir_we         = 1'b0;
    dir_waddr      = cur.dir;
    dir_wdata      = '0;
    tab_re         = 1'b0;
    tab_we         = 1'b0;
    tab_addr       = {tnum, cur.tab};
    tab_wdata      = '0;
    tnum_next      = tnum;
    next_free_next = next_free;
    count_next     = count;
    load_out       = 1'b0;
    res_status     = ST_OK;
    res_phys       = '0;
    ctl.pop        = 1'b0;
    ctl.busy       = (state == BS_CLEAR);
    unique case (state)
      BS_CLEAR: begin
        // Every table is zeroed here once, so a table taken from the pool
        // later is already clear.
        dir_we    = 1'b1;
        dir_waddr = clr_idx[IDX_W-1:0];
        tab_we    = 1'b1;
        tab_addr  = clr_idx;
        if (clr_idx == AW'(TABLE_DEPTH - 1)) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (item_valid) begin
          ctl.pop    = 1'b1;
          dir_re     = 1'b1;
          state_next = BS_DIR;
        end
      end
      BS_DIR: begin
        if (cur.op == OP_MAP && !cur.misaligned && !dir_q.present &&
            next_free != POOL_SIZE) begin
          // Take the next table from the pool and hook it into the directory.
          dir_we         = 1'b1;
          dir_wdata      = '{present: 1'b1, writable: 1'b1, user: cur.flags[FLAG_USER],
                             table_num: IDX_W'(next_free)};
          next_free_next = next_free + NW'(1);
          tnum_next      = TW'(next_free);
          tab_re         = 1'b1;
          tab_addr       = {TW'(next_free), cur.tab};
          state_next     = BS_TAB;
        end else if ((cur.op == OP_MAP || cur.op == OP_UNMAP || cur.op == OP_XLATE) &&
                     !cur.misaligned && dir_q.present) begin
          tnum_next  = dir_q.table_num[TW-1:0];
          tab_re     = 1'b1;
          tab_addr   = {dir_q.table_num[TW-1:0], cur.tab};
          state_next = BS_TAB;
        end else if (can_out) begin
          load_out   = 1'b1;
          state_next = BS_IDLE;
          if (cur.misaligned) begin
            res_status = ST_MISALIGNED;
          end else if (cur.op == OP_MAP) begin
            res_status = ST_NO_TABLES;
          end else if (cur.op == OP_UNMAP || cur.op == OP_XLATE) begin
            res_status = ST_NOT_MAPPED;
          end
        end
      end
      BS_TAB: begin
        if (can_out) begin
          load_out   = 1'b1;
          state_next = BS_IDLE;
          if (!tab_q[0]) begin
            if (cur.op == OP_MAP) begin
              tab_we    = 1'b1;
              tab_wdata = {cur.frame, cur.flags | OFF_W'(1)};
              if (count != CNT_MAX) begin
                count_next = count + CNT_W'(1);
              end
            end else begin
              res_status = ST_NOT_MAPPED;
            end
          end else if (cur.op == OP_MAP) begin
            res_status = ST_ALREADY;
          end else if (cur.op == OP_UNMAP) begin
            tab_we = 1'b1;
            if (count != '0) begin
              count_next = count - CNT_W'(1);
            end
          end else begin
            res_phys = {tab_q[31:12], cur.off};
          end
        end
      end
      default: state_next = BS_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_q <= dir_mem[dir_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_addr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_q <= tab_mem[tab_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur <= item;
    end
    tnum <= tnum_next;
    if (load_out) begin
      ostatus <= res_status;
      ophys   <= res_phys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_CLEAR;
      clr_idx   <= '0;
      next_free <= '0;
      count     <= '0;
      ov        <= 1'b0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      count     <= count_next;
      if (state == BS_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (load_out) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign rsp.valid        = ov;
  assign rsp.status       = ostatus;
  assign rsp.phys_out     = ophys;
  assign rsp.mapped_count = count;

endmodule

[hdl/two_level_page_table_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Two-level page table: 1024-entry directory plus a pool of second-level
// tables, serving map, unmap and translate requests.
// ----------------------------------------------------------------------------
// Usage: requests come in on req (op, virt_addr, phys_addr, page_flags) and
// each gives exactly one result on rsp (status, phys_out, mapped_count), in
// order. A transfer happens on a clock edge with valid and ready both high.
// In the back part a request goes through queue pop with directory read,
// then table read, then table write-back and result register; the table
// read is skipped when the directory alone decides the result. The back
// part walks one request at a time through the dependent synchronous
// memory reads, while the queue can take further requests.
// A two-entry queue sits between the request decode and the table walk, and
// the result register lets the next request start while a result waits.
// When rsp stalls, the walk holds at its last step and the queue fills,
// then req.ready drops. After reset the directory and all second-level
// tables are cleared one table entry per cycle, NUM_TABLE_PAGES * 1024
// table entries (4096 by default), with req.ready low.
// ----------------------------------------------------------------------------
module two_level_page_table_manager
  import pgt_pkg::*;
#(
  parameter int NUM_TABLE_PAGES = 4
) (
  input  logic      clk,
  input  logic      rst,
  pgt_req_if.sink   req,
  pgt_rsp_if.source rsp
);

  back_ctl_t ctl;
  logic      item_valid;
  pgt_item_t item;

  pgt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  pgt_back #(
    .NUM_TABLE_PAGES (NUM_TABLE_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .ctl        (ctl),
    .rsp        (rsp)
  );

endmodule

[hdl/pgt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_checker
// Port-level checks for the page table manager, bound to the top level.
// ----------------------------------------------------------------------------
module pgt_checker
  import pgt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [31:0] phys_out,
  input logic [12:0] mapped_count
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status <= ST_NO_TABLES))
    else $error("status code out of range");

  a_phys_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (phys_out == 32'd0))
    else $error("phys_out nonzero on a failed request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) &&
                                   $stable(phys_out) && $stable(mapped_count)))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> (!rsp_valid && !req_ready && mapped_count == 13'd0))
    else $error("block not quiet after reset");

endmodule

bind two_level_page_table_manager pgt_checker u_pgt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .phys_out     (rsp.phys_out),
  .mapped_count (rsp.mapped_count)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the two-level page table manager. It sends map, unmap and
// translate requests with random idle gaps and receiver stalls. A page table
// model inside the bench predicts each result, and every result is checked
// in order.
// ----------------------------------------------------------------------------
module tb;
  import pgt_pkg::*;

  localparam int POOL_TABLES = 4;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys;
    logic [12:0] count;
  } page_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgt_req_if req_if ();
  pgt_rsp_if rsp_if ();

  two_level_page_table_manager #(.NUM_TABLE_PAGES(POOL_TABLES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always #5 clk = ~clk;

  // Page table model.
  bit          dir_present [DIR_ENTRIES];
  logic [9:0]  dir_table [DIR_ENTRIES];
  logic [31:0] pte_store [int];
  int          tables_taken;
  logic [12:0] pages_mapped;

  page_result_t pending_results[$];
  int  err_cnt;
  bit  idle_on;
  bit  holding;
  int  stall_left;
  logic [9:0] dir_pool [6];
  event start_hold;

  function automatic int slot_key(logic [31:0] va);
    return dir_table[va[31:22]] * 1024 + va[21:12];
  endfunction

  // A fresh table is all zero, so an entry never written reads as zero.
  function automatic logic [31:0] pte_at(int key);
    return pte_store.exists(key) ? pte_store[key] : 32'h0;
  endfunction

  function automatic page_result_t walk_table(logic [1:0] op, logic [31:0] va,
                                              logic [31:0] pa, logic [11:0] fl);
    page_result_t r;
    logic [9:0] d;
    int key;
    logic [31:0] pte;
    d = va[31:22];
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_MAP: begin
        if (va[11:0] != 0 || pa[11:0] != 0) begin
          r.status = ST_MISALIGNED;
        end else if (!dir_present[d] && tables_taken >= POOL_TABLES) begin
          r.status = ST_NO_TABLES;
        end else begin
          if (!dir_present[d]) begin
            dir_present[d] = 1'b1;
            dir_table[d] = tables_taken[9:0];
            tables_taken++;
          end
          key = slot_key(va);
          pte = pte_at(key);
          if (pte[0]) begin
            r.status = ST_ALREADY;
          end else begin
            pte_store[key] = {pa[31:12], fl} | 32'h1;
            if (pages_mapped != CNT_MAX) pages_mapped++;
          end
        end
      end
      OP_UNMAP: begin
        if (va[11:0] != 0) begin
          r.status = ST_MISALIGNED;
        end else if (!dir_present[d]) begin
          r.status = ST_NOT_MAPPED;
        end else begin
          key = slot_key(va);
          pte = pte_at(key);
          if (!pte[0]) begin
            r.status = ST_NOT_MAPPED;
          end else begin
            pte_store[key] = '0;
            if (pages_mapped != 0) pages_mapped--;
          end
        end
      end
      OP_XLATE: begin
        if (!dir_present[d]) begin
          r.status = ST_NOT_MAPPED;
        end else begin
          key = slot_key(va);
          pte = pte_at(key);
          if (!pte[0]) r.status = ST_NOT_MAPPED;
          else r.phys = {pte[31:12], 12'h000} + 32'(va[11:0]);
        end
      end
      default: ;
    endcase
    r.count = pages_mapped;
    return r;
  endfunction

  task automatic send_req(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                          logic [11:0] fl);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.virt_addr  <= va;
    req_if.phys_addr  <= pa;
    req_if.page_flags <= fl;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(walk_table(op, va, pa, fl));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", 32'(rsp_if.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.phys_out !== want.phys)
          report_mismatch("phys_out", rsp_if.phys_out, want.phys);
        if (rsp_if.mapped_count !== want.count)
          report_mismatch("mapped_count", 32'(rsp_if.mapped_count), 32'(want.count));
      end
    end
    if (holding) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps going.
  initial begin
    holding = 1'b0;
    forever begin
      @(start_hold);
      holding <= 1'b1;
      repeat (300) @(posedge clk);
      holding <= 1'b0;
    end
  end

  function automatic logic [31:0] pick_page();
    logic [9:0] tab;
    tab = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
    if ($urandom_range(0, 19) == 0) tab = 10'h3FF;
    return {dir_pool[$urandom_range(0, 5)], tab, 12'h000};
  endfunction

  task automatic send_random(int n);
    logic [1:0] op;
    logic [31:0] va, pa;
    int pick;
    repeat (n) begin
      va = pick_page();
      pa = {20'($urandom), 12'h000};
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_MAP;
      else if (pick < 65) op = OP_UNMAP;
      else if (pick < 95) op = OP_XLATE;
      else op = OP_NOP;
      if (op == OP_XLATE) va[11:0] = 12'($urandom);
      if (pick % 10 == 0 && op != OP_NOP) begin
        if (op == OP_MAP && $urandom_range(0, 1)) pa[11:0] = 12'($urandom_range(1, 4095));
        else va[11:0] = 12'($urandom_range(1, 4095));
      end
      if (op == OP_NOP && $urandom_range(0, 1)) va = $urandom;
      send_req(op, va, pa, 12'($urandom));
    end
  endtask

  task automatic test_directed();
    send_req(OP_MAP, 32'h0000_0000, 32'h0000_0000, 12'h000);
    send_req(OP_XLATE, 32'h0000_0FFF, 32'h0, 12'h0);
    send_req(OP_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 12'hFFF);
    send_req(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h0);
    send_req(OP_MAP, 32'hFFFF_F000, 32'h1234_5000, 12'h004);
    send_req(OP_MAP, 32'h0000_1001, 32'h0000_2000, 12'h0);
    send_req(OP_MAP, 32'h0000_1000, 32'h0000_2FFF, 12'h0);
    send_req(OP_UNMAP, 32'hFFFF_F800, 32'h0, 12'h0);
    send_req(OP_UNMAP, 32'h0040_0000, 32'h0, 12'h0);
    send_req(OP_XLATE, 32'h0040_0123, 32'h0, 12'h0);
    send_req(OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h0);
    send_req(OP_XLATE, 32'hFFFF_F000, 32'h0, 12'h0);
    send_req(OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h0);
    send_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_req(OP_MAP, {dir_pool[2], 22'h0}, 32'hAAAA_A000, 12'h004);
    send_req(OP_MAP, {dir_pool[3], 22'h0}, 32'h5555_5000, 12'hFFB);
    // The pool is now empty, so a fifth directory entry cannot get a table.
    send_req(OP_MAP, {dir_pool[4], 22'h0}, 32'h0000_1000, 12'h0);
    send_req(OP_XLATE, {dir_pool[4], 22'h3ABC}, 32'h0, 12'h0);
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    send_random(1400);
  endtask

  task automatic test_backpressure();
    -> start_hold;
    send_random(40);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    send_random(340);
  endtask

  initial begin
    int waited;
    req_if.valid = 1'b0;
    req_if.op = OP_NOP;
    req_if.virt_addr = '0;
    req_if.phys_addr = '0;
    req_if.page_flags = '0;
    rsp_if.ready = 1'b0;
    err_cnt = 0;
    idle_on = 1'b1;
    stall_left = 0;
    tables_taken = 0;
    pages_mapped = '0;
    dir_pool[0] = 10'h000;
    dir_pool[1] = 10'h3FF;
    for (int i = 2; i < 6; i++) dir_pool[i] = 10'h001 + 10'(i * 170 + $urandom_range(0, 100));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    req_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[two_level_page_table_manager.f]
hdl/pgt_pkg.sv
hdl/pgt_req_if.sv
hdl/pgt_rsp_if.sv
hdl/pgt_front.sv
hdl/pgt_back.sv
hdl/two_level_page_table_manager.sv
hdl/pgt_checker.sv
tb/tb.sv
